### rtl/rsbb_pkg.sv
// Shared constants, types and a saturation helper for the rotated scaled box bounds unit.
package rsbb_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int QUAT_FRAC   = 30;
   localparam int VEC_W       = 32;
   localparam int MID_W       = 63;
   localparam int PROD_W      = 96;

   localparam logic [2:0] REQ_CENTER  = 3'd0;
   localparam logic [2:0] REQ_HALF    = 3'd1;
   localparam logic [2:0] REQ_SCALE   = 3'd2;
   localparam logic [2:0] REQ_ROT     = 3'd3;
   localparam logic [2:0] REQ_COMPUTE = 3'd4;

   localparam logic signed [MID_W+1:0] MID_POS =
      signed'((MID_W+2)'(1) << (MID_W-2));
   localparam logic signed [MID_W+1:0] MID_NEG = -MID_POS;

   localparam logic signed [MID_W-1:0] CMAX =
      signed'(MID_W'((MID_W'(1) << (COORD_WIDTH-1)) - MID_W'(1)));
   localparam logic signed [MID_W-1:0] CMIN = -CMAX - MID_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_ROT,
      ST_FINISH
   } state_type;

   // Limit a widened sum to the intermediate range of +/- 2^61.
   function automatic logic signed [MID_W-1:0] sat_mid(input logic signed [MID_W+1:0] x);
      logic signed [MID_W-1:0] r;
      if (x > MID_POS) begin
         r = MID_POS[MID_W-1:0];
      end else if (x < MID_NEG) begin
         r = MID_NEG[MID_W-1:0];
      end else begin
         r = x[MID_W-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/rotated_scaled_box_bounds_unit.sv
// Top level: bounding box of a scaled, rotated and translated box on one shared multiplier.
//
// Load the box center, half extents, scale and rotation quaternion with one word each
// (req_tuser 0..3); a load gives no result. A word of kind 4
// carries the translation and starts the computation: six scaling multiplies, then for
// each of the eight corners fifteen quaternion multiplies, all on one 32x32 multiplier
// that builds each 32x63 product from two partial products. Every multiply runs in five
// phases (two partial products, accumulate, round and limit, apply). After the last
// multiply the result word is loaded once the output register is free (rsp_tready).
// The unit is not ready for a new word while it computes. Loads are taken while a result
// word still waits on the output register. Unknown kinds 5..7 are dropped.
module rotated_scaled_box_bounds_unit import rsbb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vec_x [31:0], vec_y [63:32], vec_z [95:64], vec_w [127:96]
   input  logic [127:0] req_tdata,
   // req_type [2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // center_x [31:0], center_y [63:32], center_z [95:64], half_x [126:96],
   // half_y [157:127], half_z [188:158], zero [191:189]
   output logic [191:0] rsp_tdata
);

   // Held transform and box.
   logic signed [VEC_W-1:0] center_ff [3];
   logic signed [VEC_W-1:0] half_ff   [3];
   logic signed [VEC_W-1:0] scale_ff  [3];
   logic signed [VEC_W-1:0] rot_ff    [4];
   logic signed [VEC_W-1:0] trans_ff  [3];

   // Scaled box and rotation scratch.
   logic signed [VEC_W-1:0] sc_ff [3];
   logic signed [VEC_W-1:0] sh_ff [3];
   logic signed [MID_W-1:0] t_ff  [3];
   logic signed [MID_W-1:0] u_ff  [3];
   logic signed [MID_W-1:0] lo_ff [3];
   logic signed [MID_W-1:0] hi_ff [3];
   logic signed [MID_W-1:0] tmp_ff;
   logic signed [MID_W-1:0] mres_ff;

   // Shared multiplier pipeline.
   logic [63:0]       prod_ff;
   logic [PROD_W-1:0] acc_ff;

   // Sequencer.
   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [2:0] phase_ff, phase_in;
   logic [2:0] corner_ff, corner_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [191:0] rsp_data_ff;
   logic       rsp_load;

   logic req_fire;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Next state: walk phases of one multiply, steps of a pass, corners of the box.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      phase_in  = phase_ff;
      corner_in = corner_ff;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser == REQ_COMPUTE) begin
               state_in  = ST_SCALE;
               step_in   = 4'd0;
               phase_in  = 3'd0;
               corner_in = 3'd0;
            end
         end
         ST_SCALE: begin
            phase_in = phase_ff + 3'd1;
            if (phase_ff == 3'd4) begin
               phase_in = 3'd0;
               if (step_ff == 4'd5) begin
                  state_in = ST_ROT;
                  step_in  = 4'd0;
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end
         end
         ST_ROT: begin
            phase_in = phase_ff + 3'd1;
            if (phase_ff == 3'd4) begin
               phase_in = 3'd0;
               if (step_ff == 4'd14) begin
                  step_in = 4'd0;
                  if (corner_ff == 3'd7) begin
                     state_in = ST_FINISH;
                  end else begin
                     corner_in = corner_ff + 3'd1;
                  end
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         phase_ff     <= '0;
         corner_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Corner of the scaled box selected by the corner count, one bit per axis.
   logic signed [MID_W-1:0] cv [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (corner_ff[k]) begin
            cv[k] = MID_W'(sc_ff[k]) + MID_W'(sh_ff[k]);
         end else begin
            cv[k] = MID_W'(sc_ff[k]) - MID_W'(sh_ff[k]);
         end
      end
   end

   // Operand selection for the shared multiplier.
   logic [1:0] kk, ai, bi;
   logic signed [VEC_W-1:0] op_a;
   logic signed [MID_W-1:0] op_b;
   logic use_q;
   always_comb begin
      kk    = (step_ff < 4'd3) ? step_ff[1:0] : 2'(step_ff - 4'd3);
      ai    = 2'd0;
      bi    = 2'd0;
      op_a  = scale_ff[kk];
      op_b  = (step_ff < 4'd3) ? MID_W'(center_ff[kk]) : MID_W'(half_ff[kk]);
      use_q = 1'b0;
      if (state_ff == ST_ROT) begin
         use_q = 1'b1;
         case (step_ff)
            4'd0, 4'd6:   begin ai = 2'd1; bi = 2'd2; end
            4'd1, 4'd7:   begin ai = 2'd2; bi = 2'd1; end
            4'd2, 4'd8:   begin ai = 2'd2; bi = 2'd0; end
            4'd3, 4'd9:   begin ai = 2'd0; bi = 2'd2; end
            4'd4, 4'd10:  begin ai = 2'd0; bi = 2'd1; end
            4'd5, 4'd11:  begin ai = 2'd1; bi = 2'd0; end
            4'd12:        begin ai = 2'd3; bi = 2'd0; end
            4'd13:        begin ai = 2'd3; bi = 2'd1; end
            4'd14:        begin ai = 2'd3; bi = 2'd2; end
            default:      begin ai = 2'd0; bi = 2'd0; end
         endcase
         op_a = rot_ff[ai];
         op_b = (step_ff < 4'd6) ? cv[bi] : t_ff[bi];
      end
   end

   // Sign and magnitude of the operands.
   logic            prod_neg;
   logic [VEC_W-1:0] ua;
   logic [MID_W-1:0] ub;
   assign prod_neg = op_a[VEC_W-1] ^ op_b[MID_W-1];
   assign ua = op_a[VEC_W-1] ? VEC_W'(-op_a) : VEC_W'(op_a);
   assign ub = op_b[MID_W-1] ? MID_W'(-op_b) : MID_W'(op_b);

   // Round to nearest, ties away from zero, then limit the magnitude to 2^61.
   logic [PROD_W-1:0] rnd_q, rnd_f, mag;
   logic [MID_W-1:0]  mag_lim;
   always_comb begin
      rnd_q = (acc_ff + (PROD_W'(1) << (QUAT_FRAC-1))) >> QUAT_FRAC;
      rnd_f = (acc_ff + (PROD_W'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
      mag   = use_q ? rnd_q : rnd_f;
      if (mag > PROD_W'(MID_POS)) begin
         mag_lim = MID_POS[MID_W-1:0];
      end else begin
         mag_lim = mag[MID_W-1:0];
      end
   end

   // Step results.
   logic signed [MID_W-1:0] diff_s, r_s, sc_val;
   logic [1:0] rk;
   always_comb begin
      diff_s = sat_mid((MID_W+2)'(tmp_ff) - (MID_W+2)'(mres_ff));
      rk     = 2'(step_ff - 4'd12);
      r_s    = sat_mid((MID_W+2)'(sat_mid((MID_W+2)'(cv[rk]) + (MID_W+2)'(mres_ff)))
                       + (MID_W+2)'(u_ff[rk]));
      if (mres_ff > CMAX) begin
         sc_val = CMAX;
      end else if (mres_ff < CMIN) begin
         sc_val = CMIN;
      end else begin
         sc_val = mres_ff;
      end
   end

   // Final half span and center, all three axes at once.
   logic [191:0] rsp_word;
   always_comb begin
      logic signed [MID_W:0]   span;
      logic signed [MID_W:0]   hs;
      logic signed [MID_W+2:0] ctr;
      logic signed [VEC_W-1:0] c32;
      logic [VEC_W-2:0]        h31;
      rsp_word = '0;
      for (int k = 0; k < 3; k++) begin
         span = (MID_W+1)'(hi_ff[k]) - (MID_W+1)'(lo_ff[k]);
         hs   = span >>> 1;
         ctr  = (MID_W+3)'(lo_ff[k]) + (MID_W+3)'(hs) + (MID_W+3)'(trans_ff[k]);
         if (ctr > (MID_W+3)'(32'sh7FFF_FFFF)) begin
            c32 = 32'sh7FFF_FFFF;
         end else if (ctr < -(MID_W+3)'(33'sh0_8000_0000)) begin
            c32 = 32'sh8000_0000;
         end else begin
            c32 = ctr[VEC_W-1:0];
         end
         if (hs > (MID_W+1)'(32'sh7FFF_FFFF)) begin
            h31 = '1;
         end else if (hs < 0) begin
            h31 = '0;
         end else begin
            h31 = hs[VEC_W-2:0];
         end
         rsp_word[k*32 +: 32]      = c32;
         rsp_word[96 + k*31 +: 31] = h31;
      end
   end

   // Held vectors: loads in idle, reset to the identity transform.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            center_ff[k] <= '0;
            half_ff[k]   <= '0;
            scale_ff[k]  <= VEC_W'(1) << FRAC_BITS;
            rot_ff[k]    <= '0;
         end
         rot_ff[3] <= VEC_W'(1) << QUAT_FRAC;
      end else if (req_fire) begin
         case (req_tuser)
            REQ_CENTER: for (int k = 0; k < 3; k++) center_ff[k] <= req_tdata[k*32 +: 32];
            REQ_HALF:   for (int k = 0; k < 3; k++) half_ff[k]   <= req_tdata[k*32 +: 32];
            REQ_SCALE:  for (int k = 0; k < 3; k++) scale_ff[k]  <= req_tdata[k*32 +: 32];
            REQ_ROT:    for (int k = 0; k < 4; k++) rot_ff[k]    <= req_tdata[k*32 +: 32];
            default: ;
         endcase
      end
   end

   // Datapath: multiplier phases and step results.
   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == REQ_COMPUTE) begin
         for (int k = 0; k < 3; k++) trans_ff[k] <= req_tdata[k*32 +: 32];
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_word;
      end
      if (state_ff == ST_SCALE || state_ff == ST_ROT) begin
         case (phase_ff)
            3'd0: prod_ff <= 64'(ua) * 64'(ub[31:0]);
            3'd1: begin
               acc_ff  <= PROD_W'(prod_ff);
               prod_ff <= 64'(ua) * 64'(ub[MID_W-1:32]);
            end
            3'd2: acc_ff <= acc_ff + {prod_ff, 32'd0};
            3'd3: mres_ff <= prod_neg ? -signed'(mag_lim) : signed'(mag_lim);
            3'd4: begin
               if (state_ff == ST_SCALE) begin
                  if (step_ff < 4'd3) begin
                     sc_ff[kk] <= sc_val[VEC_W-1:0];
                  end else begin
                     sh_ff[kk] <= sc_val[VEC_W-1:0];
                  end
               end else if (step_ff < 4'd12) begin
                  if (!step_ff[0]) begin
                     tmp_ff <= mres_ff;
                  end else if (step_ff < 4'd6) begin
                     // double the cross product for t
                     t_ff[step_ff[2:1]] <= sat_mid((MID_W+2)'(diff_s) + (MID_W+2)'(diff_s));
                  end else begin
                     u_ff[2'((step_ff - 4'd6) >> 1)] <= diff_s;
                  end
               end else begin
                  // fold the rotated corner into the running bounds
                  if (corner_ff == 3'd0 || r_s < lo_ff[rk]) lo_ff[rk] <= r_s;
                  if (corner_ff == 3'd0 || r_s > hi_ff[rk]) hi_ff[rk] <= r_s;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

### rtl/rsbb_checker.sv
// Port-level checker for the rotated scaled box bounds unit, with its bind.
module rsbb_checker import rsbb_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [2:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [191:0] rsp_tdata
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // A compute word makes the unit busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == REQ_COMPUTE |=> !req_tready)
      else $error("ready right after a compute word");

   // No result appears right after a compute word when none was pending.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == REQ_COMPUTE && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result word too early");

endmodule

bind rotated_scaled_box_bounds_unit rsbb_checker u_rsbb_checker (.*);
